// File: rtl/alsc_pkg.sv
// ----------------------------------------------------------------------------
// alsc_pkg: size class calculator package
// Widths, tier constants, status codes, pipeline item type and divider step.
// ----------------------------------------------------------------------------
package alsc_pkg;

	localparam int REQ_W    = 24;
	localparam int ROUND_W  = 25;
	localparam int IDX_W    = 8;
	localparam int BATCH_W  = 10;
	localparam int PAGE_W   = 14;
	localparam int STATUS_W = 2;
	localparam int TIER_W   = 3;

	localparam int PAGE_SHIFT_BITS_DEF = 13;
	localparam int MAX_SMALL_BYTES     = 262144;

	localparam int BATCH_MAX = 512;
	localparam int BATCH_MIN = 2;
	localparam int DIV_LO    = MAX_SMALL_BYTES / BATCH_MAX;
	localparam int DIV_HI    = MAX_SMALL_BYTES / BATCH_MIN;
	localparam int QUO_W     = $clog2(BATCH_MAX);
	localparam int REM_W     = $clog2(MAX_SMALL_BYTES);
	localparam int DIV_STEPS = 3;
	localparam int PROD_W    = BATCH_W + REQ_W;

	localparam logic [REM_W-1:0] DIV_INIT_REM = REM_W'(MAX_SMALL_BYTES >> QUO_W);

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LARGE = 2'd2;

	localparam logic [TIER_W-1:0] TIER_8B   = 3'd0;
	localparam logic [TIER_W-1:0] TIER_16B  = 3'd1;
	localparam logic [TIER_W-1:0] TIER_128B = 3'd2;
	localparam logic [TIER_W-1:0] TIER_1K   = 3'd3;
	localparam logic [TIER_W-1:0] TIER_8K   = 3'd4;
	localparam logic [TIER_W-1:0] TIER_PAGE = 3'd5;

	localparam int TIER0_TOP = 128;
	localparam int TIER1_TOP = 1024;
	localparam int TIER2_TOP = 8 * 1024;
	localparam int TIER3_TOP = 64 * 1024;

	localparam int OFF_16B  = 16;
	localparam int OFF_128B = 72;
	localparam int OFF_1K   = 128;
	localparam int OFF_8K   = 184;

	typedef struct packed {
		logic [REQ_W-1:0]    size;
		logic [ROUND_W-1:0]  rounded;
		logic [TIER_W-1:0]   tier;
		logic [IDX_W-1:0]    idx;
		logic [STATUS_W-1:0] status;
	} alsc_item_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic             bit_q;
	} alsc_div_step_t;

	function automatic alsc_div_step_t div_step(input logic [REM_W-1:0] rem,
			input logic [REM_W-1:0] dvs);
		logic [REM_W-1:0] shifted;
		alsc_div_step_t   res;
		shifted = {rem[REM_W-2:0], 1'b0};
		if (shifted >= dvs) begin
			res.rem   = shifted - dvs;
			res.bit_q = 1'b1;
		end else begin
			res.rem   = shifted;
			res.bit_q = 1'b0;
		end
		return res;
	endfunction

endpackage

// File: rtl/alloc_size_class_calculator_unit.sv
// ----------------------------------------------------------------------------
// alloc_size_class_calculator_unit: allocation size class calculator
// Rounds a request to its tier, finds its class index, batch count and span
// page count over a six-stage pipeline.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  request | in_valid, in_ready, request_size          | in
//  result  | out_valid, out_ready, rounded_size,       | out
//          | class_index, batch_count, page_count,     |
//          | status                                    |
//
//  One transaction enters per cycle unless a stalled output has backed the
//  pipeline up. The batch divider yields three quotient bits per stage over
//  three stages, followed by the batch multiply and the page shift stages.
//  Reset clears all stage valid bits; no clearing pass.
//  A stall holds only the stages that are full behind the stalled output.
// ----------------------------------------------------------------------------
module alloc_size_class_calculator_unit
	import alsc_pkg::*;
#(
	parameter int PAGE_SHIFT_BITS = PAGE_SHIFT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [REQ_W-1:0]    request_size,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ROUND_W-1:0]  rounded_size,
	output logic [IDX_W-1:0]    class_index,
	output logic [BATCH_W-1:0]  batch_count,
	output logic [PAGE_W-1:0]   page_count,
	output logic [STATUS_W-1:0] status
);

	localparam logic [ROUND_W-1:0] PAGE_MASK =
		ROUND_W'((64'd1 << PAGE_SHIFT_BITS) - 64'd1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	alsc_item_t item_c, item_c2, item_s1, item_s2, item_s3, item_s4, item_s5;
	logic [ROUND_W-1:0] align_m1;
	logic [ROUND_W-1:0] slot_full;

	logic [REM_W-1:0] rem_s2, rem_s3;
	logic [QUO_W-1:0] quo_s2, quo_s3, quo_s4;
	logic [REM_W-1:0] rem_c2, rem_c3, rem_c4;
	logic [QUO_W-1:0] quo_c2, quo_c3, quo_c4;
	alsc_div_step_t   st2, st3, st4;

	logic [BATCH_W-1:0] batch_c, batch_s5;
	logic [PROD_W-1:0]  prod_s5;
	logic [PROD_W-1:0]  prod_sh;
	logic [PAGE_W-1:0]  pages_c;

	assign adv6     = !v_s6 || out_ready;
	assign adv5     = !v_s5 || adv6;
	assign adv4     = !v_s4 || adv5;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// stage 1: tier decode and rounding
	always_comb begin
		item_c      = '0;
		item_c.size = request_size;
		if (request_size <= REQ_W'(TIER0_TOP)) begin
			item_c.tier = TIER_8B;
		end else if (request_size <= REQ_W'(TIER1_TOP)) begin
			item_c.tier = TIER_16B;
		end else if (request_size <= REQ_W'(TIER2_TOP)) begin
			item_c.tier = TIER_128B;
		end else if (request_size <= REQ_W'(TIER3_TOP)) begin
			item_c.tier = TIER_1K;
		end else if (request_size <= REQ_W'(MAX_SMALL_BYTES)) begin
			item_c.tier = TIER_8K;
		end else begin
			item_c.tier = TIER_PAGE;
		end
		case (item_c.tier)
			TIER_8B:   align_m1 = ROUND_W'(7);
			TIER_16B:  align_m1 = ROUND_W'(15);
			TIER_128B: align_m1 = ROUND_W'(127);
			TIER_1K:   align_m1 = ROUND_W'(1023);
			TIER_8K:   align_m1 = ROUND_W'(8191);
			default:   align_m1 = PAGE_MASK;
		endcase
		item_c.rounded = ({1'b0, request_size} + align_m1) & ~align_m1;
		if (request_size == '0) begin
			item_c.status  = ST_ZERO;
			item_c.rounded = '0;
		end else if (item_c.tier == TIER_PAGE) begin
			item_c.status = ST_LARGE;
		end else begin
			item_c.status = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) item_s1 <= item_c;
	end

	// stage 2: class index, first quotient bits
	always_comb begin
		case (item_s1.tier)
			TIER_8B:   slot_full = (item_s1.rounded >> 3) - ROUND_W'(1);
			TIER_16B:  slot_full = ((item_s1.rounded - ROUND_W'(TIER0_TOP)) >> 4)
				+ ROUND_W'(OFF_16B - 1);
			TIER_128B: slot_full = ((item_s1.rounded - ROUND_W'(TIER1_TOP)) >> 7)
				+ ROUND_W'(OFF_128B - 1);
			TIER_1K:   slot_full = ((item_s1.rounded - ROUND_W'(TIER2_TOP)) >> 10)
				+ ROUND_W'(OFF_1K - 1);
			TIER_8K:   slot_full = ((item_s1.rounded - ROUND_W'(TIER3_TOP)) >> 13)
				+ ROUND_W'(OFF_8K - 1);
			default:   slot_full = '0;
		endcase
		item_c2     = item_s1;
		item_c2.idx = (item_s1.status == ST_OK) ? slot_full[IDX_W-1:0] : '0;
		rem_c2 = DIV_INIT_REM;
		quo_c2 = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			st2    = div_step(rem_c2, item_s1.size[REM_W-1:0]);
			rem_c2 = st2.rem;
			quo_c2 = {quo_c2[QUO_W-2:0], st2.bit_q};
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			item_s2 <= item_c2;
			rem_s2  <= rem_c2;
			quo_s2  <= quo_c2;
		end
	end

	// stage 3: next quotient bits
	always_comb begin
		rem_c3 = rem_s2;
		quo_c3 = quo_s2;
		for (int i = 0; i < DIV_STEPS; i++) begin
			st3    = div_step(rem_c3, item_s2.size[REM_W-1:0]);
			rem_c3 = st3.rem;
			quo_c3 = {quo_c3[QUO_W-2:0], st3.bit_q};
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			item_s3 <= item_s2;
			rem_s3  <= rem_c3;
			quo_s3  <= quo_c3;
		end
	end

	// stage 4: last quotient bits
	always_comb begin
		rem_c4 = rem_s3;
		quo_c4 = quo_s3;
		for (int i = 0; i < DIV_STEPS; i++) begin
			st4    = div_step(rem_c4, item_s3.size[REM_W-1:0]);
			rem_c4 = st4.rem;
			quo_c4 = {quo_c4[QUO_W-2:0], st4.bit_q};
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			item_s4 <= item_s3;
			quo_s4  <= quo_c4;
		end
	end

	// stage 5: clamp batch, multiply
	always_comb begin
		if (item_s4.status == ST_ZERO) begin
			batch_c = '0;
		end else if (item_s4.size <= REQ_W'(DIV_LO)) begin
			batch_c = BATCH_W'(BATCH_MAX);
		end else if (item_s4.size > REQ_W'(DIV_HI)) begin
			batch_c = BATCH_W'(BATCH_MIN);
		end else begin
			batch_c = {{(BATCH_W - QUO_W){1'b0}}, quo_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			item_s5  <= item_s4;
			batch_s5 <= batch_c;
			prod_s5  <= PROD_W'(batch_c) * PROD_W'(item_s4.size);
		end
	end

	// stage 6: page shift and output register
	always_comb begin
		prod_sh = prod_s5 >> PAGE_SHIFT_BITS;
		pages_c = prod_sh[PAGE_W-1:0];
		if (item_s5.status == ST_ZERO) begin
			pages_c = '0;
		end else if (pages_c == '0) begin
			pages_c = PAGE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			rounded_size <= item_s5.rounded;
			class_index  <= item_s5.idx;
			batch_count  <= batch_s5;
			page_count   <= pages_c;
			status       <= item_s5.status;
		end
	end

endmodule

// File: sim/alloc_size_class_calculator_unit_checker.sv
// ----------------------------------------------------------------------------
// alloc_size_class_calculator_unit_checker: result checker
// Watches the request and result channels, predicts the rounded size, class
// index, batch count, page count and status of each accepted request, and
// compares every result field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module alloc_size_class_calculator_unit_checker
	import alsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [REQ_W-1:0]    request_size,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [ROUND_W-1:0]  rounded_size,
	input  logic [IDX_W-1:0]    class_index,
	input  logic [BATCH_W-1:0]  batch_count,
	input  logic [PAGE_W-1:0]   page_count,
	input  logic [STATUS_W-1:0] status,
	output int                  mismatches,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ROUND_W-1:0]  rounded;
		logic [IDX_W-1:0]    idx;
		logic [BATCH_W-1:0]  batch;
		logic [PAGE_W-1:0]   pages;
		logic [STATUS_W-1:0] status;
	} size_class_t;

	size_class_t predicted_classes [$];

	function automatic size_class_t size_class_of(input logic [REQ_W-1:0] req);
		longint unsigned sz;
		longint unsigned tier_base;
		longint unsigned grain;
		longint unsigned batch;
		longint unsigned pages;
		int unsigned     shift;
		int unsigned     offset;
		size_class_t     r;
		sz = req;
		r  = '0;
		if (sz == 0) begin
			r.status = ST_ZERO;
			return r;
		end
		r.status = ST_OK;
		if (sz <= 128) begin
			shift = 3; tier_base = 0; offset = 0;
		end else if (sz <= 1024) begin
			shift = 4; tier_base = 128; offset = 16;
		end else if (sz <= 8192) begin
			shift = 7; tier_base = 1024; offset = 72;
		end else if (sz <= 65536) begin
			shift = 10; tier_base = 8192; offset = 128;
		end else if (sz <= 262144) begin
			shift = 13; tier_base = 65536; offset = 184;
		end else begin
			shift = PAGE_SHIFT_BITS_DEF; tier_base = 0; offset = 0;
			r.status = ST_LARGE;
		end
		grain     = 64'd1 << shift;
		r.rounded = ROUND_W'(((sz + grain - 1) >> shift) << shift);
		if (r.status == ST_OK)
			r.idx = IDX_W'(((sz - tier_base + grain - 1) >> shift) - 1 + offset);
		batch = 64'd262144 / sz;
		if (batch > 512)
			batch = 512;
		else if (batch < 2)
			batch = 2;
		pages = (batch * sz) >> PAGE_SHIFT_BITS_DEF;
		if (pages == 0)
			pages = 1;
		r.batch = BATCH_W'(batch);
		r.pages = PAGE_W'(pages);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		size_class_t want;
		int          bad;
		if (!arst_n) begin
			predicted_classes.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (out_valid && out_ready) begin
				if (predicted_classes.size() == 0) begin
					$error("unexpected result: rounded_size %0d, status %0d", rounded_size, status);
					bad++;
				end else begin
					want = predicted_classes.pop_front();
					if (rounded_size !== want.rounded) begin
						$error("rounded_size: expected %0d, actual %0d", want.rounded, rounded_size);
						bad++;
					end
					if (class_index !== want.idx) begin
						$error("class_index: expected %0d, actual %0d", want.idx, class_index);
						bad++;
					end
					if (batch_count !== want.batch) begin
						$error("batch_count: expected %0d, actual %0d", want.batch, batch_count);
						bad++;
					end
					if (page_count !== want.pages) begin
						$error("page_count: expected %0d, actual %0d", want.pages, page_count);
						bad++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						bad++;
					end
				end
			end
			if (in_valid && in_ready)
				predicted_classes.push_back(size_class_of(request_size));
			mismatches  <= mismatches + bad;
			outstanding <= predicted_classes.size();
		end
	end

endmodule

// File: sim/alloc_size_class_calculator_unit_test.sv
// ----------------------------------------------------------------------------
// alloc_size_class_calculator_unit_test: size class calculator testbench
// Sends tier edges, zero and oversize requests, then random requests spread
// over every tier, with random idling on both channels and one long result
// stall that backs the pipeline up; the checker predicts and compares.
// ----------------------------------------------------------------------------
module alloc_size_class_calculator_unit_test
	import alsc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1626;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_START   = 150;
	localparam int HOLD_LEN     = 300;
	localparam int SINK_STEADY  = 1100;
	localparam int SINK_WAVY    = 1500;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [REQ_W-1:0]    request_size = '0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [ROUND_W-1:0]  rounded_size;
	logic [IDX_W-1:0]    class_index;
	logic [BATCH_W-1:0]  batch_count;
	logic [PAGE_W-1:0]   page_count;
	logic [STATUS_W-1:0] status;
	int                  mismatches;
	int                  outstanding;
	int unsigned         cycles = 0;

	int unsigned directed_sizes [24] = '{
		0, 1, 7, 8, 9, 128, 129, 512, 513, 1024, 1025, 8192, 8193,
		65536, 65537, 131072, 131073, 262143, 262144, 262145,
		8388608, 5592405, 11184810, 16777215
	};
	int unsigned tier_edges [7] = '{8, 128, 1024, 8192, 65536, 131072, 262144};

	alloc_size_class_calculator_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.request_size (request_size),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rounded_size (rounded_size),
		.class_index  (class_index),
		.batch_count  (batch_count),
		.page_count   (page_count),
		.status       (status)
	);

	alloc_size_class_calculator_unit_checker check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.request_size (request_size),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rounded_size (rounded_size),
		.class_index  (class_index),
		.batch_count  (batch_count),
		.page_count   (page_count),
		.status       (status),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** alloc_size_class_calculator_unit: FAILED **");
			$finish;
		end
	end

	task automatic send_request(input logic [REQ_W-1:0] size, input bit may_idle);
		while (may_idle && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		request_size <= size;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	initial begin : result_sink
		int unsigned sink_cycle;
		sink_cycle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			sink_cycle++;
			if (sink_cycle >= HOLD_START && sink_cycle < HOLD_START + HOLD_LEN)
				out_ready <= 1'b0;
			else if (sink_cycle >= SINK_STEADY && sink_cycle < SINK_WAVY)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(99) >= 8);
		end
	end

	initial begin : request_source
		logic [REQ_W-1:0] size;
		int unsigned      pick;
		@(posedge arst_n);
		@(posedge clk);
		foreach (directed_sizes[i])
			send_request(REQ_W'(directed_sizes[i]), 1'b1);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(99);
			if (pick < 3)
				size = '0;
			else if (pick < 20)
				size = REQ_W'($urandom_range(128, 1));
			else if (pick < 35)
				size = REQ_W'($urandom_range(1024, 129));
			else if (pick < 50)
				size = REQ_W'($urandom_range(8192, 1025));
			else if (pick < 63)
				size = REQ_W'($urandom_range(65536, 8193));
			else if (pick < 76)
				size = REQ_W'($urandom_range(262144, 65537));
			else if (pick < 86)
				size = REQ_W'(tier_edges[$urandom_range(6)] + $urandom_range(4) - 2);
			else
				size = REQ_W'($urandom());
			send_request(size, !(n >= 700 && n < 1000));
		end
		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** alloc_size_class_calculator_unit: PASSED **");
		else
			$display("** alloc_size_class_calculator_unit: FAILED **");
		$finish;
	end

endmodule
